// ===== hw/rtl/rzb_pkg.sv =====
package rzb_pkg;

  localparam int TEX_SIZE    = 32;
  localparam int TEX_BITS    = $clog2(TEX_SIZE);
  localparam int TEX_CELLS   = TEX_SIZE * TEX_SIZE;
  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 200;
  localparam int ANGLE_STEPS = 256;
  localparam int ANGLE_W     = $clog2(ANGLE_STEPS);

  localparam int ADDR_W   = 10;
  localparam int VAL_W    = 8;
  localparam int X_W      = 9;
  localparam int Y_W      = 8;
  localparam int ZOOM_W   = 32;
  localparam int ASPECT_W = 18;
  localparam int SINE_W   = 18;
  localparam int ACC_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int MUL_W    = ACC_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH   = 2;

  localparam logic [ACC_W-1:0] CENTRE = ACC_W'((TEX_SIZE / 2) << FRAC_W);
  localparam logic signed [MUL_W-1:0] HALF_W = MUL_W'(SCREEN_W / 2);
  localparam logic signed [MUL_W-1:0] HALF_H = MUL_W'(SCREEN_H / 2);

  localparam logic [ANGLE_W-1:0]  ANGLE_RST  = '0;
  localparam logic [ZOOM_W-1:0]   ZOOM_RST   = ZOOM_W'(65536);
  localparam logic [ASPECT_W-1:0] ASPECT_RST = ASPECT_W'(78643);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Denominators (2k)(2k+1) of the Taylor terms for k = 1 to 10.
  localparam logic [63:0] TAYLOR_DEN [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef enum logic {
    OP_TEXEL_WR = 1'b0,
    OP_PIXEL    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE  = 2'd0,
    CFG_ZOOM   = 2'd1,
    CFG_ASPECT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_LOAD, SQ_M0, SQ_M1, SQ_M2, SQ_M3, SQ_M4,
    SQ_M5, SQ_M6, SQ_M7, SQ_M8, SQ_DONE
  } seq_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
  } q_entry_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle;
    logic [ZOOM_W-1:0]   zoom;
    logic [ASPECT_W-1:0] aspect;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] cu;
    logic [ACC_W-1:0] cv;
    logic [ACC_W-1:0] ru;
    logic [ACC_W-1:0] rv;
    logic [ACC_W-1:0] su;
    logic [ACC_W-1:0] sv;
  } step_res_t;

  typedef logic signed [SINE_W-1:0] sine_tab_t [ANGLE_STEPS];

  // Rounded signed 2.16 sine from an eleven-term integer Taylor series in Q30.
  function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned i);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic        neg;
    a    = 64'(4 * i);
    neg  = 1'b0;
    if (a >= 64'(2 * ANGLE_STEPS)) begin
      neg = 1'b1;
      a   = a - 64'(2 * ANGLE_STEPS);
    end
    if (a > 64'(ANGLE_STEPS)) begin
      a = 64'(2 * ANGLE_STEPS) - a;
    end
    x    = (a * PI_Q30) >> (ANGLE_W + 1);
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = x;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DEN[k - 1];
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 8192) / 16384;
    if (sum > 65536) begin
      sum = 65536;
    end
    if (neg) begin
      sum = -sum;
    end
    return SINE_W'(sum);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine();

endpackage

// ===== hw/rtl/rzb_in_if.sv =====
interface rzb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [rzb_pkg::ADDR_W-1:0]  texel_address;
  logic [rzb_pkg::VAL_W-1:0]   texel_value;

  modport source (output valid, kind, texel_address, texel_value, input ready);
  modport sink (input valid, kind, texel_address, texel_value, output ready);
endinterface

// ===== hw/rtl/rzb_out_if.sv =====
interface rzb_out_if;
  logic                      valid;
  logic                      ready;
  logic [rzb_pkg::VAL_W-1:0] pixel_value;
  logic [rzb_pkg::X_W-1:0]   pixel_x;
  logic [rzb_pkg::Y_W-1:0]   pixel_y;
  logic                      frame_last;

  modport source (output valid, pixel_value, pixel_x, pixel_y, frame_last, input ready);
  modport sink (input valid, pixel_value, pixel_x, pixel_y, frame_last, output ready);
endinterface

// ===== hw/rtl/rzb_cfg_if.sv =====
interface rzb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rzb_pkg::CFG_IDX_W-1:0]  index;
  logic [rzb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rzb_front.sv =====
module rzb_front (
  input  logic              clk,
  input  logic              rst_n,
  rzb_in_if.sink            in_ch,
  output logic              q_vld,
  output rzb_pkg::q_entry_t q_head,
  input  logic              q_pop
);
  import rzb_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_entry_t          q_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              push;
  q_entry_t          entry;

  assign in_ch.ready = (cnt_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_vld       = (cnt_r != '0);
  assign q_head      = q_r[rd_ptr_r];

  always_comb begin
    entry.op    = op_t'(in_ch.kind);
    entry.addr  = in_ch.texel_address;
    entry.value = in_ch.texel_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CNT_W'(cnt_r + CNT_W'(push) - CNT_W'(q_pop));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/rzb_step_unit.sv =====
module rzb_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  rzb_pkg::cfg_t      cfg,
  input  logic               start,
  output logic               done,
  output rzb_pkg::step_res_t res
);
  import rzb_pkg::*;

  seq_t                      state_r;
  seq_t                      state_nxt;
  logic [ANGLE_W-1:0]        aq;
  logic signed [SINE_W-1:0]  sin_q_r;
  logic signed [SINE_W-1:0]  sin_a_r;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]          prod_hi;
  logic [ACC_W-1:0]          prod_lo;
  logic signed [MUL_W-1:0]   zoom_x;
  logic signed [MUL_W-1:0]   asp_x;
  logic [ACC_W-1:0]          neg_cv;
  step_res_t                 res_r;

  assign aq      = ANGLE_W'(cfg.angle + ANGLE_W'(ANGLE_STEPS / 4));
  assign prod_hi = prod_r[FRAC_W +: ACC_W];
  assign prod_lo = prod_r[ACC_W-1:0];
  assign zoom_x  = MUL_W'(signed'(cfg.zoom));
  assign asp_x   = MUL_W'({1'b0, cfg.aspect});
  assign neg_cv  = ACC_W'(0) - res_r.cv;
  assign res     = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_LOAD;
        end
      end
      SQ_LOAD: state_nxt = SQ_M0;
      SQ_M0:   state_nxt = SQ_M1;
      SQ_M1:   state_nxt = SQ_M2;
      SQ_M2:   state_nxt = SQ_M3;
      SQ_M3:   state_nxt = SQ_M4;
      SQ_M4:   state_nxt = SQ_M5;
      SQ_M5:   state_nxt = SQ_M6;
      SQ_M6:   state_nxt = SQ_M7;
      SQ_M7:   state_nxt = SQ_M8;
      SQ_M8:   state_nxt = SQ_DONE;
      SQ_DONE: state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    done  = 1'b0;
    case (state_r)
      SQ_M0: begin
        mul_a = MUL_W'(sin_q_r);
        mul_b = zoom_x;
      end
      SQ_M1: begin
        mul_a = MUL_W'(sin_a_r);
        mul_b = zoom_x;
      end
      SQ_M2: begin
        mul_a = MUL_W'(signed'(res_r.cu));
        mul_b = asp_x;
      end
      SQ_M3: begin
        mul_a = MUL_W'(signed'(neg_cv));
        mul_b = asp_x;
      end
      SQ_M4: begin
        mul_a = MUL_W'(signed'(res_r.cu));
        mul_b = HALF_W;
      end
      SQ_M5: begin
        mul_a = MUL_W'(signed'(res_r.ru));
        mul_b = HALF_H;
      end
      SQ_M6: begin
        mul_a = MUL_W'(signed'(res_r.cv));
        mul_b = HALF_W;
      end
      SQ_M7: begin
        mul_a = MUL_W'(signed'(res_r.rv));
        mul_b = HALF_H;
      end
      SQ_DONE: done = 1'b1;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Each of the states M1 to M8 latches the product started in the state before it.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      SQ_LOAD: begin
        sin_q_r <= SINE_ROM[aq];
        sin_a_r <= SINE_ROM[cfg.angle];
      end
      SQ_M1: res_r.cu <= prod_hi;
      SQ_M2: res_r.cv <= prod_hi;
      SQ_M3: res_r.rv <= prod_hi;
      SQ_M4: res_r.ru <= prod_hi;
      SQ_M5: res_r.su <= prod_lo;
      SQ_M6: res_r.su <= CENTRE - (res_r.su + prod_lo);
      SQ_M7: res_r.sv <= prod_lo;
      SQ_M8: res_r.sv <= CENTRE - (res_r.sv + prod_lo);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/rzb_back.sv =====
module rzb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  rzb_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output logic               step_start,
  input  logic               step_done,
  input  rzb_pkg::step_res_t step_res,
  rzb_out_if.source          out_ch
);
  import rzb_pkg::*;

  logic [VAL_W-1:0]    tex_mem [TEX_CELLS];

  logic [ACC_W-1:0] cu_r;
  logic [ACC_W-1:0] cv_r;
  logic [ACC_W-1:0] ru_r;
  logic [ACC_W-1:0] rv_r;
  logic [ACC_W-1:0] rsu_r;
  logic [ACC_W-1:0] rsv_r;
  logic [ACC_W-1:0] cur_u_r;
  logic [ACC_W-1:0] cur_v_r;
  logic [ACC_W-1:0] rsu_nxt;
  logic [ACC_W-1:0] rsv_nxt;
  logic [X_W-1:0]   col_r;
  logic [Y_W-1:0]   row_r;
  logic             frame_rdy_r;
  logic             setup_busy_r;
  logic             rd_vld_r;
  logic [X_W-1:0]   rd_x_r;
  logic [Y_W-1:0]   rd_y_r;
  logic             rd_last_r;
  logic [VAL_W-1:0] mem_rd_r;
  logic             out_vld_r;
  logic [VAL_W-1:0] out_val_r;
  logic [X_W-1:0]   out_x_r;
  logic [Y_W-1:0]   out_y_r;
  logic             out_last_r;

  logic              head_pix;
  logic              at_start;
  logic              col_end;
  logic              row_end;
  logic              rd_adv;
  logic              pix_go;
  logic              wr_go;
  logic [ADDR_W-1:0] tex_addr;

  assign head_pix   = q_vld && (q_head.op == OP_PIXEL);
  assign at_start   = (col_r == '0) && (row_r == '0);
  assign col_end    = (col_r == X_W'(SCREEN_W - 1));
  assign row_end    = (row_r == Y_W'(SCREEN_H - 1));
  assign rd_adv     = rd_vld_r && (!out_vld_r || out_ch.ready);
  assign step_start = head_pix && at_start && !frame_rdy_r && !setup_busy_r;
  assign pix_go     = head_pix && (!at_start || frame_rdy_r) && (!rd_vld_r || rd_adv);
  assign wr_go      = q_vld && (q_head.op == OP_TEXEL_WR);
  assign q_pop      = pix_go || wr_go;
  assign tex_addr   = ADDR_W'({cur_v_r[FRAC_W +: TEX_BITS], cur_u_r[FRAC_W +: TEX_BITS]});
  assign rsu_nxt    = rsu_r + ru_r;
  assign rsv_nxt    = rsv_r + rv_r;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.pixel_value = out_val_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.frame_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      tex_mem[q_head.addr] <= q_head.value;
    end
    if (pix_go) begin
      mem_rd_r <= tex_mem[tex_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (step_done) begin
      cu_r    <= step_res.cu;
      cv_r    <= step_res.cv;
      ru_r    <= step_res.ru;
      rv_r    <= step_res.rv;
      rsu_r   <= step_res.su;
      rsv_r   <= step_res.sv;
      cur_u_r <= step_res.su;
      cur_v_r <= step_res.sv;
    end else if (pix_go) begin
      if (col_end) begin
        rsu_r   <= rsu_nxt;
        rsv_r   <= rsv_nxt;
        cur_u_r <= rsu_nxt;
        cur_v_r <= rsv_nxt;
      end else begin
        cur_u_r <= cur_u_r + cu_r;
        cur_v_r <= cur_v_r + cv_r;
      end
    end
    if (pix_go) begin
      rd_x_r    <= col_r;
      rd_y_r    <= row_r;
      rd_last_r <= col_end && row_end;
    end
    if (rd_adv) begin
      out_val_r  <= mem_rd_r;
      out_x_r    <= rd_x_r;
      out_y_r    <= rd_y_r;
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      frame_rdy_r  <= 1'b0;
      setup_busy_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (pix_go) begin
        if (col_end) begin
          col_r <= '0;
          row_r <= row_end ? '0 : Y_W'(row_r + 1'b1);
        end else begin
          col_r <= X_W'(col_r + 1'b1);
        end
      end
      if (step_start) begin
        setup_busy_r <= 1'b1;
      end else if (step_done) begin
        setup_busy_r <= 1'b0;
      end
      if (step_done) begin
        frame_rdy_r <= 1'b1;
      end else if (pix_go) begin
        frame_rdy_r <= 1'b0;
      end
      if (pix_go) begin
        rd_vld_r <= 1'b1;
      end else if (rd_adv) begin
        rd_vld_r <= 1'b0;
      end
      if (rd_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/affine_rotozoom_texture_blit.sv =====
// Rotating and scaling blitter over a 32x32 byte tile and a 320x200 screen. Load the
// tile with texel-write items first; each later pixel-request item returns one pixel in
// raster order, with the frame's last pixel flagged. Pixels stream at one per cycle
// once a frame is under way, while the output is ready; the first pixel of each frame
// waits while a single shared 33x33 multiplier, run by a sequencer, derives the step
// deltas and the centered start point from the sine table and the angle, zoom and
// aspect registers. A pixel passes through the registered texel store read and then
// the output register on its way out of the back end. A two-item queue separates the
// input side from the back end. Register writes take effect at the next frame start.
module affine_rotozoom_texture_blit (
  input  logic      clk,
  input  logic      rst_n,
  rzb_in_if.sink    in_ch,
  rzb_out_if.source out_ch,
  rzb_cfg_if.sink   cfg_ch
);
  import rzb_pkg::*;

  cfg_t      cfg_r;
  logic      q_vld;
  q_entry_t  q_head;
  logic      q_pop;
  logic      step_start;
  logic      step_done;
  step_res_t step_res;
  logic      cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle  <= ANGLE_RST;
      cfg_r.zoom   <= ZOOM_RST;
      cfg_r.aspect <= ASPECT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_ANGLE:  cfg_r.angle  <= cfg_ch.data[ANGLE_W-1:0];
        CFG_ZOOM:   cfg_r.zoom   <= cfg_ch.data[ZOOM_W-1:0];
        CFG_ASPECT: cfg_r.aspect <= cfg_ch.data[ASPECT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rzb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_vld  (q_vld),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  rzb_step_unit u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .start (step_start),
    .done  (step_done),
    .res   (step_res)
  );

  rzb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .step_start (step_start),
    .step_done  (step_done),
    .step_res   (step_res),
    .out_ch     (out_ch)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("queue popped while empty");

  a_setup_takes_time: assert property (@(posedge clk) disable iff (!rst_n)
    step_start |=> !step_done)
    else $error("step setup finished too early");

  a_no_pop_during_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_start |-> !(q_pop && q_head.op == OP_PIXEL))
    else $error("pixel taken before frame setup");

  a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_last) |->
      (out_ch.pixel_x == X_W'(SCREEN_W - 1)) && (out_ch.pixel_y == Y_W'(SCREEN_H - 1)))
    else $error("frame end flagged away from the last pixel");

endmodule
